[rtl/cmmb_pkg.sv]
// ----------------------------------------------------------------------------
// cmmb_pkg
// Types and constants for the CAN message mailbox buffer: field widths,
// beat layout, opcodes, stored entry format and sequencer states.
// ----------------------------------------------------------------------------
package cmmb_pkg;

  localparam int ID_W       = 29;
  localparam int LEN_W      = 4;
  localparam int PAY_W      = 64;
  localparam int RIDX_W     = 4;
  localparam int OIDX_W     = 4;

  // Input beat: msg_id, msg_length, msg_payload, read_index, zero pad
  localparam int IN_FIELDS_W  = ID_W + LEN_W + PAY_W + RIDX_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  // Output beat: entry_index, found_existing, out_id, out_length, out_payload
  localparam int OUT_FIELDS_W = OIDX_W + 1 + ID_W + LEN_W + PAY_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_HISTORY = 1'b0;
  localparam logic MODE_MAILBOX = 1'b1;

  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [LEN_W-1:0] length;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

[rtl/can_message_mailbox_buffer.sv]
// ----------------------------------------------------------------------------
// can_message_mailbox_buffer
// Receive store for CAN messages: history ring or mailbox filing by
// identifier, one shared identifier comparator stepped over the entries.
// ----------------------------------------------------------------------------
// Sequence, beat accepted to result in the output register: a read goes from
// IDLE through the registered entry read to OUT; a history-mode store goes
// IDLE, WRITE, OUT; a mailbox store goes IDLE, SCAN, WRITE, OUT, the scan
// comparing one entry per cycle through the single read port of the entry
// memory until entry k matches or the last entry has been compared.
// One item at a time; the next beat is taken the cycle after the result is
// loaded. A result waiting on m_tready holds.
// Reset clears all entry valid bits (invalid entries read as zero), the head
// pointer and the mode register; no clearing pass.
module can_message_mailbox_buffer #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: buffer_mode
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // msg_id[28:0], msg_length[32:29], msg_payload[96:33], read_index[100:97]
  input  logic [cmmb_pkg::IN_DATA_W-1:0] s_tdata,
  // opcode[0]
  input  logic                           s_tuser,
  // Output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // entry_index[3:0], found_existing[4], out_id[33:5], out_length[37:34],
  // out_payload[101:38]
  output logic [cmmb_pkg::OUT_DATA_W-1:0] m_tdata
);

  import cmmb_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Input beat fields
  logic [ID_W-1:0]   in_id;
  logic [LEN_W-1:0]  in_len;
  logic [PAY_W-1:0]  in_pay;
  logic [RIDX_W-1:0] in_ridx;
  logic              in_range;

  assign in_id    = s_tdata[ID_W-1:0];
  assign in_len   = s_tdata[ID_W +: LEN_W];
  assign in_pay   = s_tdata[ID_W+LEN_W +: PAY_W];
  assign in_ridx  = s_tdata[ID_W+LEN_W+PAY_W +: RIDX_W];
  assign in_range = (32'(in_ridx) < ENTRIES);

  // Control and request registers
  state_t            state;
  state_t            state_next;
  logic              buffer_mode;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  head_next;
  logic [ENTRIES-1:0] valid;

  logic              req_op;
  logic [ID_W-1:0]   req_id;
  logic [LEN_W-1:0]  req_len;
  logic [PAY_W-1:0]  req_pay;
  logic [RIDX_W-1:0] req_ridx;
  logic              req_range;

  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_pending;
  logic [IDX_W-1:0]  slot;
  logic              found;

  // Entry memory
  entry_t            mem [ENTRIES];
  entry_t            rd_data;
  logic              rd_valid;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic              load_out;

  logic              accept;
  logic [ID_W-1:0]   cmp_id;
  logic              match;

  assign accept    = s_tvalid && s_tready;
  assign cmp_id    = rd_valid ? rd_data.id : '0;
  assign match     = cmp_pending && (cmp_id == req_id);
  assign head_next = (head == LAST_IDX) ? '0 : IDX_W'(head + 1'b1);

  // Sequencer
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cnt;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == OP_READ) begin
            rd_en      = in_range;
            rd_addr    = IDX_W'(in_ridx);
            state_next = ST_OUT;
          end else if (buffer_mode == MODE_MAILBOX) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_SCAN: begin
        if (match || (cmp_pending && cmp_idx == LAST_IDX)) begin
          state_next = ST_WRITE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_mode <= MODE_HISTORY;
    end else if (cfg_wr_en) begin
      buffer_mode <= cfg_wr_data;
    end
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= s_tuser;
      req_id    <= in_id;
      req_len   <= in_len;
      req_pay   <= in_pay;
      req_ridx  <= in_ridx;
      req_range <= in_range;
      cnt       <= '0;
      cmp_idx   <= '0;
      slot      <= head;
      found     <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (match) begin
        found <= 1'b1;
        slot  <= cmp_idx;
      end
      if (rd_en) begin
        cmp_idx <= cnt;
        cnt     <= IDX_W'(cnt + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pending <= 1'b0;
    end else if (accept) begin
      cmp_pending <= 1'b0;
    end else if (state == ST_SCAN && rd_en) begin
      cmp_pending <= 1'b1;
    end
  end

  // Head pointer and entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      valid <= '0;
    end else if (wr_en) begin
      valid[slot] <= 1'b1;
      if (!found) begin
        head <= head_next;
      end
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= '{payload: req_pay, length: req_len, id: req_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // Result register
  logic [OIDX_W-1:0] res_index;
  logic              res_found;
  logic [ID_W-1:0]   res_id;
  logic [LEN_W-1:0]  res_len;
  logic [PAY_W-1:0]  res_pay;
  logic              res_hit;

  always_comb begin
    res_hit   = (req_op == OP_READ) && req_range && rd_valid;
    res_index = (req_op == OP_READ) ? req_ridx : OIDX_W'(slot);
    res_found = (req_op == OP_STORE) && found;
    res_id    = res_hit ? rd_data.id : '0;
    res_len   = res_hit ? rd_data.length : '0;
    res_pay   = res_hit ? rd_data.payload : '0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_DATA_W'({res_pay, res_len, res_id, res_found, res_index});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Checks
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_IDX)
    else $error("head pointer beyond last entry");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("new beat taken while an item is in progress");

  a_head_moves_on_write: assert property (@(posedge clk) disable iff (rst)
    !$stable(head) |-> ($past(rst) || $past(wr_en && !found)))
    else $error("head pointer moved without a new-entry write");

  a_found_mailbox_only: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_found) |-> (buffer_mode == MODE_MAILBOX))
    else $error("match reported outside mailbox mode");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN message mailbox buffer. A shadow copy of
// the entry store predicts every result beat: history ring filing, mailbox
// filing by identifier and entry reads. A short directed opening is followed
// by random phases that alternate the buffer mode. Both stream sides get
// random idle bursts except in the third and the final random phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmmb_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int POOL_SIZE   = 20;
  localparam int PHASE_BEATS = 258;
  localparam int MAX_REPORTS = 30;

  // Result beat layout
  localparam int O_FOUND = OIDX_W;
  localparam int O_ID    = O_FOUND + 1;
  localparam int O_LEN   = O_ID + ID_W;
  localparam int O_PAY   = O_LEN + LEN_W;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
    logic [RIDX_W-1:0] ridx;
  } can_beat_t;

  typedef struct packed {
    logic [OIDX_W-1:0] idx;
    logic              found;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
  } mbox_result_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  s_tvalid    = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata     = '0;
  logic                  s_tuser     = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready    = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow of the entry store
  logic [ID_W-1:0]  shadow_ids  [ENTRIES];
  logic [LEN_W-1:0] shadow_lens [ENTRIES];
  logic [PAY_W-1:0] shadow_pays [ENTRIES];
  int unsigned      shadow_head;
  logic             shadow_mode;

  can_beat_t    tx_queue[$];
  mbox_result_t expected_results[$];
  can_beat_t    cur_beat;
  can_beat_t    next_beat;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  bit idle_on = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int errors = 0;
  int stores_sent = 0;
  int reads_sent = 0;
  int overwrites_seen = 0;
  int results_seen = 0;
  int mode_writes = 0;

  can_message_mailbox_buffer #(.ENTRIES(ENTRIES)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mbox_result_t file_or_fetch(input can_beat_t b);
    mbox_result_t r;
    int slot;
    int i;
    bit hit;
    r = '0;
    slot = 0;
    hit = 1'b0;
    if (b.op == OP_READ) begin
      r.idx = b.ridx;
      if (int'(b.ridx) < ENTRIES) begin
        r.id  = shadow_ids[b.ridx];
        r.len = shadow_lens[b.ridx];
        r.pay = shadow_pays[b.ridx];
      end
      return r;
    end
    if (shadow_mode == MODE_MAILBOX) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (!hit && shadow_ids[i] == b.id) begin
          slot = i;
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      slot = shadow_head;
      shadow_head = (shadow_head + 1 >= ENTRIES) ? 0 : shadow_head + 1;
    end
    shadow_ids[slot]  = b.id;
    shadow_lens[slot] = b.len;
    shadow_pays[slot] = b.pay;
    r.idx   = slot[OIDX_W-1:0];
    r.found = hit;
    return r;
  endfunction

  function automatic can_beat_t make_store(input logic [ID_W-1:0] id,
                                           input logic [LEN_W-1:0] len,
                                           input logic [PAY_W-1:0] pay);
    can_beat_t b;
    b.op   = OP_STORE;
    b.id   = id;
    b.len  = len;
    b.pay  = pay;
    b.ridx = RIDX_W'($urandom_range(0, 15));
    return b;
  endfunction

  function automatic can_beat_t make_read(input logic [RIDX_W-1:0] ridx);
    can_beat_t b;
    // Fill the unused fields with noise; the block must ignore them
    b.op   = OP_READ;
    b.id   = ID_W'($urandom());
    b.len  = LEN_W'($urandom_range(0, 15));
    b.pay  = {$urandom(), $urandom()};
    b.ridx = ridx;
    return b;
  endfunction

  function automatic can_beat_t random_beat(input bit from_pool);
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    if (from_pool && $urandom_range(0, 3) != 0) begin
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      id = ID_W'($urandom());
    end
    len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(9, 15))
                                      : LEN_W'($urandom_range(0, 8));
    if ($urandom_range(0, 9) < 4) begin
      return make_read(RIDX_W'($urandom_range(0, 15)));
    end
    return make_store(id, len, {$urandom(), $urandom()});
  endfunction

  task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                 input logic [PAY_W-1:0] want);
    if (errors < MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] beat);
    mbox_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result beat", beat[PAY_W-1:0], '0);
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    if (want.found) overwrites_seen++;
    if (beat[OIDX_W-1:0] !== want.idx)
      report_mismatch("entry_index", PAY_W'(beat[OIDX_W-1:0]), PAY_W'(want.idx));
    if (beat[O_FOUND] !== want.found)
      report_mismatch("found_existing", PAY_W'(beat[O_FOUND]), PAY_W'(want.found));
    if (beat[O_ID +: ID_W] !== want.id)
      report_mismatch("out_id", PAY_W'(beat[O_ID +: ID_W]), PAY_W'(want.id));
    if (beat[O_LEN +: LEN_W] !== want.len)
      report_mismatch("out_length", PAY_W'(beat[O_LEN +: LEN_W]), PAY_W'(want.len));
    if (beat[O_PAY +: PAY_W] !== want.pay)
      report_mismatch("out_payload", beat[O_PAY +: PAY_W], want.pay);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(file_or_fetch(cur_beat));
        if (cur_beat.op == OP_READ) reads_sent++;
        else stores_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (tx_queue.size() > 0) begin
          next_beat = tx_queue.pop_front();
          cur_beat <= next_beat;
          s_tvalid <= 1'b1;
          s_tuser  <= next_beat.op;
          s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, next_beat.ridx,
                       next_beat.pay, next_beat.len, next_beat.id};
          if (idle_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (recv_stall > 0) begin
        m_tready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        recv_stall <= $urandom_range(0, 9);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    // Sample at the falling edge so queue and valid have settled
    do begin
      @(negedge clk);
    end while (tx_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_mode = mode;
    mode_writes++;
  endtask

  task automatic run_random_phase(input logic mode, input bit with_idle);
    int n;
    wait_drained();
    write_mode(mode);
    idle_on = with_idle;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) id_pool[n] = ID_W'($urandom());
    for (n = 0; n < PHASE_BEATS; n++) tx_queue.push_back(random_beat(mode == MODE_MAILBOX));
  endtask

  initial begin
    int p;
    for (p = 0; p < ENTRIES; p++) begin
      shadow_ids[p]  = '0;
      shadow_lens[p] = '0;
      shadow_pays[p] = '0;
    end
    shadow_head = 0;
    shadow_mode = MODE_HISTORY;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Mailbox filing straight after reset: every entry holds identifier zero
    write_mode(MODE_MAILBOX);
    idle_on = 1'b1;
    tx_queue.push_back(make_read(4'd0));
    tx_queue.push_back(make_store('0, 4'd0, '0));
    tx_queue.push_back(make_store('1, 4'd15, '1));
    tx_queue.push_back(make_store('1, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA));
    tx_queue.push_back(make_store('0, 4'd9, 64'h5555_5555_5555_5555));
    tx_queue.push_back(make_store(29'h1234_5678, 4'd8, 64'h0123_4567_89AB_CDEF));
    tx_queue.push_back(make_read(4'd0));
    tx_queue.push_back(make_read(4'd1));
    tx_queue.push_back(make_read(4'd15));
    tx_queue.push_back(make_read(4'd2));

    // History ring: head keeps going regardless of identifier
    wait_drained();
    write_mode(MODE_HISTORY);
    tx_queue.push_back(make_store('0, 4'd15, '1));
    tx_queue.push_back(make_store('1, 4'd0, '0));
    tx_queue.push_back(make_store('1, 4'd12, 64'hFEDC_BA98_7654_3210));
    tx_queue.push_back(make_read(4'd3));
    tx_queue.push_back(make_read(4'd2));
    tx_queue.push_back(make_read(4'd4));

    for (p = 0; p < 6; p++) begin
      run_random_phase((p % 2 == 0) ? MODE_MAILBOX : MODE_HISTORY, p != 2 && p != 5);
    end

    wait_drained();
    $display("Run covered %0d beats: %0d stores, %0d reads, %0d mailbox overwrites",
             stores_sent + reads_sent, stores_sent, reads_sent, overwrites_seen);
    $display("Checked %0d result beats over %0d mode writes, %0d mismatches",
             results_seen, mode_writes, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
rtl/cmmb_pkg.sv
rtl/can_message_mailbox_buffer.sv
verif/tb_top.sv
